// ===== src/qfx_pkg.sv =====
// Shared constants, codes and item types for the Q24.8 fixed-point ALU.
// No dependencies; every other file of the block imports this package.
package qfx_pkg;

   localparam int WORD_BITS = 32;
   localparam int FRAC_BITS = 8;
   localparam int DATA_BITS = 32;
   localparam int OP_BITS   = 4;
   localparam int NUM_BITS  = WORD_BITS + FRAC_BITS;
   localparam int REM_BITS  = WORD_BITS + 1;
   localparam int PROD_BITS = 2 * WORD_BITS;
   localparam int NUM_CELLS = NUM_BITS;

   typedef enum logic [OP_BITS-1:0] {
      OP_ADD     = 4'd0,
      OP_SUB     = 4'd1,
      OP_MUL     = 4'd2,
      OP_DIV     = 4'd3,
      OP_MIN     = 4'd4,
      OP_MAX     = 4'd5,
      OP_INC     = 4'd6,
      OP_DEC     = 4'd7,
      OP_INT2FIX = 4'd8,
      OP_FIX2INT = 4'd9
   } op_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_DIV_ZERO = 2'd1,
      ST_SAT      = 2'd2
   } status_type;

   typedef logic signed [WORD_BITS-1:0] word_type;

   typedef struct packed {
      op_type                 op;
      word_type               a;
      word_type               b;
      logic [WORD_BITS-1:0]   mag_a;
      logic [WORD_BITS-1:0]   mag_b;
      logic                   neg;
      logic                   lt;
      logic                   eq;
   } prep_type;

   typedef struct packed {
      op_type                 op;
      word_type               simple;
      logic                   lt;
      logic                   eq;
      logic                   neg;
      logic                   div_zero;
      logic [PROD_BITS-1:0]   prod;
      logic [WORD_BITS-1:0]   divisor;
      logic [NUM_BITS-1:0]    num;
      logic [NUM_BITS-1:0]    quo;
      logic [REM_BITS-1:0]    rem;
   } item_type;

   typedef struct packed {
      op_type                 op;
      word_type               simple;
      logic                   lt;
      logic                   eq;
      logic                   neg;
      logic                   div_zero;
      logic [PROD_BITS-1:0]   mag;
   } fin_type;

   typedef struct packed {
      word_type               result;
      logic                   lt;
      logic                   eq;
      status_type             status;
   } rsp_type;

endpackage

// ===== src/qfx_req_if.sv =====
// Request channel of the fixed-point ALU: valid/ready plus the request item.
// Depends on qfx_pkg.
interface qfx_req_if import qfx_pkg::*; ();
   logic                        valid;
   logic                        ready;
   logic [OP_BITS-1:0]          req_type;
   logic signed [DATA_BITS-1:0] operand_a;
   logic signed [DATA_BITS-1:0] operand_b;

   modport source (output valid, output req_type, output operand_a, output operand_b,
                   input ready);
   modport sink   (input valid, input req_type, input operand_a, input operand_b,
                   output ready);
endinterface

// ===== src/qfx_rsp_if.sv =====
// Response channel of the fixed-point ALU: valid/ready plus the result item.
// Depends on qfx_pkg.
interface qfx_rsp_if import qfx_pkg::*; ();
   logic                        valid;
   logic                        ready;
   logic signed [DATA_BITS-1:0] result;
   logic                        a_less_than_b;
   logic                        a_equals_b;
   logic [1:0]                  status;

   modport source (output valid, output result, output a_less_than_b, output a_equals_b,
                   output status, input ready);
   modport sink   (input valid, input result, input a_less_than_b, input a_equals_b,
                   input status, output ready);
endinterface

// ===== src/q24_8_fixed_point_alu.sv =====
// Q24.8 fixed-point ALU: add, sub, mul, div, min, max, inc, dec and the
// int/fixed conversions, with compare flags and a status code per item.
// Request channel req: opcode and two raw operands; response channel rsp:
// one result item per request item, in request order.
// Every item flows through the same pipeline of 44 registers: two front
// stages (magnitudes, then product and the simple operations), a
// chain of 40 divider cells (one restoring step, one quotient bit each),
// and two back stages (rounding, then saturation into the output register).
// rsp.valid rises once the item reaches the output register; throughput is
// one item per cycle for as long as rsp.ready stays high. Each stage has
// its own valid bit, so when rsp.ready is low the items close up behind the
// output register and req.ready stays high while any stage ahead is empty;
// req.ready falls only when all 44 stages hold items.
// Reset (synchronous, active high) empties every stage; no item survives.
// Depends on qfx_pkg, qfx_req_if, qfx_rsp_if, qfx_prep, qfx_div_cell and
// qfx_finish.
module q24_8_fixed_point_alu import qfx_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   qfx_req_if.sink    req,
   qfx_rsp_if.source  rsp
);

   logic       chain_valid [NUM_CELLS+1];
   logic       chain_ready [NUM_CELLS+1];
   item_type   chain_item  [NUM_CELLS+1];

   qfx_prep u_prep (
      .clock    (clock),
      .reset    (reset),
      .req      (req),
      .dn_valid (chain_valid[0]),
      .dn_item  (chain_item[0]),
      .dn_ready (chain_ready[0])
   );

   for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
      qfx_div_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .up_valid (chain_valid[i]),
         .up_item  (chain_item[i]),
         .up_ready (chain_ready[i]),
         .dn_valid (chain_valid[i+1]),
         .dn_item  (chain_item[i+1]),
         .dn_ready (chain_ready[i+1])
      );
   end

   qfx_finish u_finish (
      .clock    (clock),
      .reset    (reset),
      .up_valid (chain_valid[NUM_CELLS]),
      .up_item  (chain_item[NUM_CELLS]),
      .up_ready (chain_ready[NUM_CELLS]),
      .rsp      (rsp)
   );

endmodule

// ===== src/qfx_prep.sv =====
// Front end: operand decode, magnitudes, compare flags, product and the
// simple operations, in two stages. Depends on qfx_pkg and qfx_req_if.
module qfx_prep import qfx_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   qfx_req_if.sink    req,
   output logic       dn_valid,
   output item_type   dn_item,
   input  logic       dn_ready
);

   logic       s1_valid_ff;
   prep_type   s1_ff;
   prep_type   s1_in;
   logic       s1_ready;
   logic       s2_valid_ff;
   item_type   s2_ff;
   item_type   s2_in;
   word_type   a_w;
   word_type   b_w;

   assign s1_ready  = !s1_valid_ff || !s2_valid_ff || dn_ready;
   assign req.ready = s1_ready;

   always_comb begin
      a_w         = req.operand_a[WORD_BITS-1:0];
      b_w         = req.operand_b[WORD_BITS-1:0];
      s1_in.op    = op_type'(req.req_type);
      s1_in.a     = a_w;
      s1_in.b     = b_w;
      s1_in.mag_a = a_w[WORD_BITS-1] ? WORD_BITS'(-a_w) : WORD_BITS'(a_w);
      s1_in.mag_b = b_w[WORD_BITS-1] ? WORD_BITS'(-b_w) : WORD_BITS'(b_w);
      s1_in.neg   = a_w[WORD_BITS-1] ^ b_w[WORD_BITS-1];
      s1_in.lt    = a_w < b_w;
      s1_in.eq    = a_w == b_w;
   end

   always_comb begin
      s2_in.op       = s1_ff.op;
      s2_in.lt       = s1_ff.lt;
      s2_in.eq       = s1_ff.eq;
      s2_in.neg      = s1_ff.neg;
      s2_in.div_zero = s1_ff.b == '0;
      s2_in.prod     = PROD_BITS'(s1_ff.mag_a) * PROD_BITS'(s1_ff.mag_b);
      s2_in.divisor  = s1_ff.mag_b;
      s2_in.num      = NUM_BITS'(s1_ff.mag_a) << FRAC_BITS;
      s2_in.quo      = '0;
      s2_in.rem      = '0;
      case (s1_ff.op)
         OP_ADD:     s2_in.simple = s1_ff.a + s1_ff.b;
         OP_SUB:     s2_in.simple = s1_ff.a - s1_ff.b;
         OP_MIN:     s2_in.simple = s1_ff.lt ? s1_ff.a : s1_ff.b;
         OP_MAX:     s2_in.simple = (s1_ff.lt || s1_ff.eq) ? s1_ff.b : s1_ff.a;
         OP_INC:     s2_in.simple = s1_ff.a + word_type'(1);
         OP_DEC:     s2_in.simple = s1_ff.a - word_type'(1);
         OP_INT2FIX: s2_in.simple = s1_ff.a << FRAC_BITS;
         OP_FIX2INT: s2_in.simple = s1_ff.a >>> FRAC_BITS;
         default:    s2_in.simple = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) s1_valid_ff <= req.valid;
         if (!s2_valid_ff || dn_ready) s2_valid_ff <= s1_valid_ff;
      end
      if (s1_ready && req.valid) s1_ff <= s1_in;
      if ((!s2_valid_ff || dn_ready) && s1_valid_ff) s2_ff <= s2_in;
   end

   assign dn_valid = s2_valid_ff;
   assign dn_item  = s2_ff;

endmodule

// ===== src/qfx_div_cell.sv =====
// One cell of the divider chain: a single restoring step that produces one
// quotient bit, with its own item register. Depends on qfx_pkg.
module qfx_div_cell import qfx_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       up_valid,
   input  item_type   up_item,
   output logic       up_ready,
   output logic       dn_valid,
   output item_type   dn_item,
   input  logic       dn_ready
);

   logic                  valid_ff;
   item_type              item_ff;
   item_type              item_in;
   logic [REM_BITS-1:0]   trial;
   logic                  q_bit;

   assign up_ready = !valid_ff || dn_ready;

   always_comb begin
      item_in = up_item;
      trial   = {up_item.rem[REM_BITS-2:0], up_item.num[NUM_BITS-1]};
      q_bit   = trial >= REM_BITS'(up_item.divisor);
      item_in.rem = q_bit ? trial - REM_BITS'(up_item.divisor) : trial;
      item_in.num = {up_item.num[NUM_BITS-2:0], 1'b0};
      item_in.quo = {up_item.quo[NUM_BITS-2:0], q_bit};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
      if (up_ready && up_valid) item_ff <= item_in;
   end

   assign dn_valid = valid_ff;
   assign dn_item  = item_ff;

endmodule

// ===== src/qfx_finish.sv =====
// Back end: rounding of product and quotient, saturation, result select and
// the output register. Depends on qfx_pkg and qfx_rsp_if.
module qfx_finish import qfx_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       up_valid,
   input  item_type   up_item,
   output logic       up_ready,
   qfx_rsp_if.source  rsp
);

   localparam logic [PROD_BITS-1:0] POS_LIMIT = PROD_BITS'((64'd1 << (WORD_BITS - 1)) - 64'd1);
   localparam logic [PROD_BITS-1:0] NEG_LIMIT = PROD_BITS'(64'd1 << (WORD_BITS - 1));
   localparam word_type WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
   localparam word_type WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

   logic                   f_valid_ff;
   fin_type                f_ff;
   fin_type                f_in;
   logic                   f_ready;
   logic                   o_valid_ff;
   rsp_type                o_ff;
   rsp_type                o_in;
   logic                   round_up;
   logic [PROD_BITS-1:0]   mul_mag;
   logic [PROD_BITS-1:0]   div_mag;
   word_type               low_mag;
   logic                   sat;

   assign f_ready  = !o_valid_ff || rsp.ready;
   assign up_ready = !f_valid_ff || f_ready;

   always_comb begin
      round_up = {up_item.rem, 1'b0} >= (REM_BITS+1)'(up_item.divisor);
      mul_mag  = (up_item.prod >> FRAC_BITS) + PROD_BITS'(up_item.prod[FRAC_BITS-1]);
      div_mag  = PROD_BITS'(up_item.quo) + PROD_BITS'(round_up);
      f_in.op       = up_item.op;
      f_in.simple   = up_item.simple;
      f_in.lt       = up_item.lt;
      f_in.eq       = up_item.eq;
      f_in.neg      = up_item.neg;
      f_in.div_zero = up_item.div_zero;
      f_in.mag      = (up_item.op == OP_DIV) ? div_mag : mul_mag;
   end

   always_comb begin
      low_mag     = f_ff.mag[WORD_BITS-1:0];
      sat         = f_ff.neg ? (f_ff.mag > NEG_LIMIT) : (f_ff.mag > POS_LIMIT);
      o_in.lt     = f_ff.lt;
      o_in.eq     = f_ff.eq;
      o_in.result = f_ff.simple;
      o_in.status = ST_OK;
      case (f_ff.op)
         OP_MUL, OP_DIV: begin
            if (f_ff.op == OP_DIV && f_ff.div_zero) begin
               o_in.result = '0;
               o_in.status = ST_DIV_ZERO;
            end else if (sat) begin
               o_in.result = f_ff.neg ? WORD_MIN : WORD_MAX;
               o_in.status = ST_SAT;
            end else begin
               o_in.result = f_ff.neg ? -low_mag : low_mag;
            end
         end
         default: begin
            o_in.result = f_ff.simple;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
      end else begin
         if (up_ready) f_valid_ff <= up_valid;
         if (f_ready) o_valid_ff <= f_valid_ff;
      end
      if (up_ready && up_valid) f_ff <= f_in;
      if (f_ready && f_valid_ff) o_ff <= o_in;
   end

   assign rsp.valid         = o_valid_ff;
   assign rsp.result        = DATA_BITS'(o_ff.result);
   assign rsp.a_less_than_b = o_ff.lt;
   assign rsp.a_equals_b    = o_ff.eq;
   assign rsp.status        = o_ff.status;

endmodule

// ===== test/tb.sv =====
// Testbench for q24_8_fixed_point_alu: directed corner items, then random bursts,
// checked in order against a Q24.8 predictor held in a small scoreboard class.
// Depends on qfx_pkg, qfx_req_if, qfx_rsp_if and the ALU top level.
`timescale 1ns / 100ps

module tb;
   import qfx_pkg::*;

   localparam int  NUM_RANDOM = 600;
   localparam int  DRAIN_CYCLES = 60;
   localparam int  HOLD_CYCLES = 200;
   localparam word_type W_MAX = 32'sh7FFF_FFFF;
   localparam word_type W_MIN = 32'sh8000_0000;
   localparam word_type W_ONE = 32'sh0000_0100;

   class alu_scoreboard;
      rsp_type pending[$];
      int      mismatches;
      int      accepted;

      function new();
         mismatches = 0;
         accepted = 0;
      endfunction

      function word_type clamp_word(input logic [63:0] mag, input logic neg,
                                    output logic sat);
         sat = 1'b0;
         if (neg) begin
            if (mag > 64'h8000_0000) begin
               sat = 1'b1;
               return W_MIN;
            end
            return word_type'(-mag);
         end
         if (mag > 64'h7FFF_FFFF) begin
            sat = 1'b1;
            return W_MAX;
         end
         return word_type'(mag);
      endfunction

      function rsp_type compute(logic [OP_BITS-1:0] op, word_type a, word_type b);
         rsp_type                r;
         logic signed [63:0]     wide_a;
         logic signed [63:0]     wide_b;
         logic [63:0]            mag_a;
         logic [63:0]            mag_b;
         logic [63:0]            prod;
         logic [63:0]            num;
         logic [63:0]            quo;
         logic [63:0]            rem;
         logic                   neg;
         logic                   sat;
         wide_a = a;
         wide_b = b;
         mag_a = (wide_a < 0) ? -wide_a : wide_a;
         mag_b = (wide_b < 0) ? -wide_b : wide_b;
         neg = (a < 0) ^ (b < 0);
         sat = 1'b0;
         r.result = '0;
         r.lt = (a < b);
         r.eq = (a == b);
         r.status = ST_OK;
         case (op)
            OP_ADD:     r.result = a + b;
            OP_SUB:     r.result = a - b;
            OP_MUL: begin
               prod = mag_a * mag_b;
               quo = prod >> FRAC_BITS;
               if (prod[FRAC_BITS-1]) quo = quo + 1;
               r.result = clamp_word(quo, neg, sat);
               if (sat) r.status = ST_SAT;
            end
            OP_DIV: begin
               if (b == 0) begin
                  r.status = ST_DIV_ZERO;
               end else begin
                  num = mag_a << FRAC_BITS;
                  quo = num / mag_b;
                  rem = num % mag_b;
                  if (2 * rem >= mag_b) quo = quo + 1;
                  r.result = clamp_word(quo, neg, sat);
                  if (sat) r.status = ST_SAT;
               end
            end
            OP_MIN:     r.result = (a < b) ? a : b;
            OP_MAX:     r.result = (a > b) ? a : b;
            OP_INC:     r.result = a + 32'sd1;
            OP_DEC:     r.result = a - 32'sd1;
            OP_INT2FIX: r.result = a <<< FRAC_BITS;
            OP_FIX2INT: r.result = a >>> FRAC_BITS;
            default:    r.result = '0;
         endcase
         return r;
      endfunction

      function void note_request(logic [OP_BITS-1:0] op, word_type a, word_type b);
         pending.push_back(compute(op, a, b));
         accepted++;
      endfunction

      function void check_result(word_type result, logic lt, logic eq, logic [1:0] status);
         rsp_type want;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: unexpected item result=%h lt=%b eq=%b status=%0d",
                        $realtime, result, lt, eq, status);
            return;
         end
         want = pending.pop_front();
         if (want.result !== result || want.lt !== lt || want.eq !== eq ||
             want.status !== status) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: mismatch exp result=%h lt=%b eq=%b status=%0d, got %h %b %b %0d",
                        $realtime, want.result, want.lt, want.eq, want.status,
                        result, lt, eq, status);
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   qfx_req_if req_ch ();
   qfx_rsp_if rsp_ch ();

   q24_8_fixed_point_alu uut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   alu_scoreboard board = new();
   int            burst_left = 0;

   always #10 clock = ~clock;

   task automatic send_item(logic [OP_BITS-1:0] op, word_type a, word_type b);
      int gap;
      req_ch.valid <= 1'b1;
      req_ch.req_type <= op;
      req_ch.operand_a <= a;
      req_ch.operand_b <= b;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      board.note_request(op, a, b);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap = ($urandom_range(0, 5) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 4);
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
         burst_left = $urandom_range(0, 40);
      end
   endtask

   function automatic word_type pick_operand();
      word_type corners[8];
      corners = '{32'sd0, 32'sd1, -32'sd1, W_MAX, W_MIN, W_ONE, -W_ONE, 32'sh80};
      case ($urandom_range(0, 6))
         0:       return corners[$urandom_range(0, 7)];
         1:       return word_type'($urandom_range(0, 8191)) - 32'sd4096;
         2:       return word_type'($urandom_range(0, 65535)) - 32'sd32768;
         3:       return word_type'($urandom >> $urandom_range(0, 31)) *
                         (($urandom_range(0, 1) == 1) ? -32'sd1 : 32'sd1);
         4:       return word_type'($urandom_range(0, 1_048_575)) - 32'sd524288;
         default: return word_type'($urandom);
      endcase
   endfunction

   initial begin
      logic [OP_BITS-1:0] op;
      word_type           a;
      word_type           b;
      req_ch.valid <= 1'b0;
      req_ch.req_type <= '0;
      req_ch.operand_a <= '0;
      req_ch.operand_b <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_item(OP_ADD, W_MAX, 32'sd1);
      send_item(OP_SUB, W_MIN, 32'sd1);
      send_item(OP_MUL, W_MAX, W_MAX);
      send_item(OP_MUL, W_MIN, W_MAX);
      send_item(OP_MUL, W_MIN, W_ONE);
      send_item(OP_MUL, 32'sd1, 32'sh80);
      send_item(OP_MUL, -32'sd1, 32'sh80);
      send_item(OP_MUL, 32'sd1, 32'sh7F);
      send_item(OP_DIV, W_ONE, 32'sd0);
      send_item(OP_DIV, W_ONE, 32'sh300);
      send_item(OP_DIV, -32'sh200, 32'sh300);
      send_item(OP_DIV, W_MAX, 32'sd1);
      send_item(OP_DIV, W_MIN, -W_ONE);
      send_item(OP_DIV, W_MIN, W_ONE);
      send_item(OP_MIN, W_MIN, W_MAX);
      send_item(OP_MAX, W_MIN, W_MAX);
      send_item(OP_MIN, 32'sd5, 32'sd5);
      send_item(OP_INC, W_MAX, W_MAX);
      send_item(OP_DEC, W_MIN, 32'sd0);
      send_item(OP_INT2FIX, 32'sh0080_0000, 32'sd0);
      send_item(OP_INT2FIX, -32'sd1, 32'sd3);
      send_item(OP_FIX2INT, 32'shFFFF_FF01, 32'sd0);
      send_item(OP_FIX2INT, W_MIN, W_MIN);
      send_item(4'd10, 32'sd7, -32'sd7);
      send_item(4'd15, W_MAX, W_MIN);

      repeat (NUM_RANDOM) begin
         op = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(10, 15))
                                           : 4'($urandom_range(0, 9));
         a = pick_operand();
         case ($urandom_range(0, 11))
            0:       b = a;
            1:       b = 32'sd0;
            default: b = pick_operand();
         endcase
         send_item(op, a, b);
      end
      if (burst_left > 0) req_ch.valid <= 1'b0;

      while (board.pending.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.mismatches == 0 && board.pending.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   initial begin
      int cycle;
      int hold_left;
      int next_hold_at;
      int mode;
      cycle = 0;
      hold_left = 0;
      next_hold_at = 150;
      rsp_ch.ready <= 1'b0;
      while (reset) @(posedge clock);
      forever begin
         @(posedge clock);
         if (rsp_ch.valid && rsp_ch.ready)
            board.check_result(rsp_ch.result, rsp_ch.a_less_than_b, rsp_ch.a_equals_b,
                               rsp_ch.status);
         cycle++;
         if (hold_left == 0 && board.accepted >= next_hold_at) begin
            hold_left = HOLD_CYCLES;
            next_hold_at += 300;
         end
         mode = (cycle / 50) % 4;
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else if (mode == 0) begin
            rsp_ch.ready <= 1'b1;
         end else if (mode == 1) begin
            rsp_ch.ready <= 1'($urandom_range(0, 1));
         end else if (mode == 2) begin
            rsp_ch.ready <= ((cycle % 7) < 2);
         end else begin
            rsp_ch.ready <= ($urandom_range(0, 3) != 0);
         end
      end
   end

   initial begin
      #5_000_000;
      $display("Regression FAIL");
      $finish;
   end

endmodule
